### hdl/quadrature_decoder_velocity_top_macros.svh
// Assertion macros for the quadrature decoder with period velocity.
// Taken in by the checker; needs nothing else.
`ifndef QUADRATURE_DECODER_VELOCITY_TOP_MACROS_SVH
`define QUADRATURE_DECODER_VELOCITY_TOP_MACROS_SVH

// Same-cycle implication, off while reset is held
`define QDV_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("qdv: same-cycle check failed");

// Next-cycle implication, off while reset is held
`define QDV_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("qdv: next-cycle check failed");

`endif

### hdl/qdv_pkg.sv
// Shared types and constants of the quadrature decoder with period velocity.
// Used by every module of the block; depends on nothing.
package qdv_pkg;

  // Fixed field widths
  localparam int unsigned POS_W       = 32;
  localparam int unsigned SPEED_W     = 32;
  localparam int unsigned STAMP_W     = 32;
  localparam int unsigned DIVIDEND_W  = 32;
  localparam int unsigned EDGE_MASK_W = 4;

  // Configuration port
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_EDGE_MASK = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT   = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_UPS       = 2'd2;

  localparam logic [EDGE_MASK_W-1:0] EDGE_MASK_RST = 4'd1;
  localparam logic [CFG_DATA_W-1:0]  TIMEOUT_RST   = 32'd100000;
  localparam logic [DIVIDEND_W-1:0]  UPS_RST       = 32'd1000000;

  // Bit positions in the edge mask
  localparam int unsigned MASK_A_RISE = 0;
  localparam int unsigned MASK_A_FALL = 1;
  localparam int unsigned MASK_B_RISE = 2;
  localparam int unsigned MASK_B_FALL = 3;

  // Serial divider step count
  localparam int unsigned DIV_STEP_W = $clog2(DIVIDEND_W);
  localparam logic [DIV_STEP_W-1:0] DIV_LAST = DIV_STEP_W'(DIVIDEND_W - 1);

  // Speed saturation limits
  localparam logic [SPEED_W-1:0] SPEED_MAX = {1'b0, {(SPEED_W-1){1'b1}}};
  localparam logic [SPEED_W-1:0] SPEED_MIN = {1'b1, {(SPEED_W-1){1'b0}}};

  // Per-sample edge decode flags
  typedef struct packed {
    logic counted;
    logic rev;
    logic bad;
  } qdv_edge_flags_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_DIV,
    ST_DONE
  } qdv_state_e;

endpackage

### hdl/qdv_edge.sv
// Edge decoder and position state of the quadrature decoder.
// Uses qdv_pkg for the edge mask layout and the flag struct.
module qdv_edge #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  load_i,
  input  logic                                  line_a_i,
  input  logic                                  line_b_i,
  input  logic [TIME_WIDTH-1:0]                 now_i,
  input  logic [qdv_pkg::EDGE_MASK_W-1:0]       edge_mask_i,
  output logic [COUNT_WIDTH-1:0]                count_o,
  output logic                                  reverse_o,
  output logic [TIME_WIDTH-1:0]                 last_time_o,
  output logic [TIME_WIDTH-1:0]                 prior_time_o,
  output qdv_pkg::qdv_edge_flags_t              flags_o
);

  logic                     last_a_q, last_b_q;
  logic [COUNT_WIDTH-1:0]   count_q, count_d;
  logic                     reverse_q;
  logic [TIME_WIDTH-1:0]    last_time_q, prior_time_q;
  qdv_pkg::qdv_edge_flags_t flags_q, flags_d;
  logic                     a_chg, b_chg;

  // Decode the edge in this sample against the held levels
  assign a_chg = line_a_i ^ last_a_q;
  assign b_chg = line_b_i ^ last_b_q;

  always_comb begin
    flags_d.bad     = a_chg & b_chg;
    flags_d.counted = 1'b0;
    flags_d.rev     = 1'b0;
    if (!flags_d.bad && a_chg) begin
      if (line_a_i) begin
        flags_d.counted = edge_mask_i[qdv_pkg::MASK_A_RISE];
        flags_d.rev     = line_b_i;
      end else begin
        flags_d.counted = edge_mask_i[qdv_pkg::MASK_A_FALL];
        flags_d.rev     = ~line_b_i;
      end
    end else if (!flags_d.bad && b_chg) begin
      if (line_b_i) begin
        flags_d.counted = edge_mask_i[qdv_pkg::MASK_B_RISE];
        flags_d.rev     = ~line_a_i;
      end else begin
        flags_d.counted = edge_mask_i[qdv_pkg::MASK_B_FALL];
        flags_d.rev     = line_a_i;
      end
    end
  end

  // Step the count up or down
  assign count_d = flags_d.rev ? count_q - COUNT_WIDTH'(1) : count_q + COUNT_WIDTH'(1);

  // Update levels on each accepted sample, count and edge times on a counted edge
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_a_q     <= 1'b0;
      last_b_q     <= 1'b0;
      count_q      <= '0;
      reverse_q    <= 1'b0;
      last_time_q  <= '0;
      prior_time_q <= '0;
      flags_q      <= '0;
    end else if (load_i) begin
      last_a_q <= line_a_i;
      last_b_q <= line_b_i;
      flags_q  <= flags_d;
      if (flags_d.counted) begin
        count_q      <= count_d;
        reverse_q    <= flags_d.rev;
        prior_time_q <= last_time_q;
        last_time_q  <= now_i;
      end
    end
  end

  assign count_o      = count_q;
  assign reverse_o    = reverse_q;
  assign last_time_o  = last_time_q;
  assign prior_time_o = prior_time_q;
  assign flags_o      = flags_q;

endmodule

### hdl/qdv_div.sv
// Bit-serial restoring divider, one quotient bit per cycle.
// Uses qdv_pkg for the dividend width and the step count.
module qdv_div #(
  parameter int unsigned DIVISOR_W = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [qdv_pkg::DIVIDEND_W-1:0]  dividend_i,
  input  logic [DIVISOR_W-1:0]            divisor_i,
  output logic                            done_o,
  output logic [qdv_pkg::DIVIDEND_W-1:0]  quotient_o
);

  localparam int unsigned DW = qdv_pkg::DIVIDEND_W;

  logic                           busy_q;
  logic [qdv_pkg::DIV_STEP_W-1:0] cnt_q;
  logic [DW-1:0]                  quo_q, quo_d;
  logic [DIVISOR_W-1:0]           rem_q, rem_d, dvs_q;
  logic [DIVISOR_W:0]             trial, diff;
  logic                           ge;

  // Trial subtract of the divisor from the shifted remainder
  assign trial = {rem_q, quo_q[DW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign ge    = ~diff[DIVISOR_W];
  assign rem_d = ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
  assign quo_d = {quo_q[DW-2:0], ge};

  // Control: load on start, count down one step per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= qdv_pkg::DIV_LAST;
    end else if (busy_q) begin
      busy_q <= (cnt_q != '0);
      cnt_q  <= cnt_q - qdv_pkg::DIV_STEP_W'(1);
    end
  end

  // Datapath: shift the dividend out as the quotient shifts in
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
  end

  assign done_o     = busy_q && (cnt_q == '0);
  assign quotient_o = quo_q;

endmodule

### hdl/quadrature_decoder_velocity_top.sv
// Top level of the quadrature decoder with period velocity.
// Depends on qdv_pkg, qdv_edge and qdv_div.
//
//   channel  | signals                          | direction
//   ---------+----------------------------------+----------
//   input    | in_valid_i / in_stall_o          | sample word in
//   output   | out_valid_o / out_stall_i        | result word out
//   config   | cfg_we_i, cfg_addr_i, cfg_data_i | register write
//
// A word's result is formed in steps: the accepting edge updates the edge
// state, the load state checks the timeout and loads the divider, the serial
// divider runs 32 steps (one quotient bit per cycle) and the done state
// registers the result. Words are taken one at a time, so the next is accepted
// only after the last one's result is registered; a new one is accepted
// while a finished result waits on out_stall_i, and its own result then holds
// until the waiting one is taken.
// After reset the block takes words at once, with no clearing pass.
module quadrature_decoder_velocity_top #(
  parameter int unsigned TIME_WIDTH  = 32,
  parameter int unsigned COUNT_WIDTH = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [qdv_pkg::CFG_ADDR_W-1:0]    cfg_addr_i,
  input  logic [qdv_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              line_a_i,
  input  logic                              line_b_i,
  input  logic [qdv_pkg::STAMP_W-1:0]       time_now_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic signed [qdv_pkg::POS_W-1:0]  position_o,
  output logic                              moving_reverse_o,
  output logic signed [qdv_pkg::SPEED_W-1:0] speed_o,
  output logic                              edge_counted_o,
  output logic                              bad_transition_o
);

  localparam int unsigned CMP_W = (TIME_WIDTH > qdv_pkg::CFG_DATA_W) ?
                                  TIME_WIDTH : qdv_pkg::CFG_DATA_W;

  qdv_pkg::qdv_state_e state_q, state_d;

  logic [qdv_pkg::EDGE_MASK_W-1:0] edge_mask_q;
  logic [qdv_pkg::CFG_DATA_W-1:0]  timeout_q;
  logic [qdv_pkg::DIVIDEND_W-1:0]  ups_q;

  logic                            in_acc, out_free, out_load, div_start, div_done;
  logic [TIME_WIDTH-1:0]           now_q, elapsed, period;
  logic                            timeout_hit_q, zero_period_q;
  logic [COUNT_WIDTH-1:0]          count;
  logic                            reverse;
  logic [TIME_WIDTH-1:0]           last_time, prior_time;
  qdv_pkg::qdv_edge_flags_t        flags;
  logic [qdv_pkg::DIVIDEND_W-1:0]  quotient;
  logic [qdv_pkg::SPEED_W-1:0]     speed_d;
  logic                            out_valid_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      edge_mask_q <= qdv_pkg::EDGE_MASK_RST;
      timeout_q   <= qdv_pkg::TIMEOUT_RST;
      ups_q       <= qdv_pkg::UPS_RST;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        qdv_pkg::REG_EDGE_MASK: edge_mask_q <= cfg_data_i[qdv_pkg::EDGE_MASK_W-1:0];
        qdv_pkg::REG_TIMEOUT:   timeout_q   <= cfg_data_i;
        qdv_pkg::REG_UPS:       ups_q       <= cfg_data_i[qdv_pkg::DIVIDEND_W-1:0];
        default: ;
      endcase
    end
  end

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // Edge decode and position state
  qdv_edge #(
    .TIME_WIDTH  (TIME_WIDTH),
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_edge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (in_acc),
    .line_a_i     (line_a_i),
    .line_b_i     (line_b_i),
    .now_i        (TIME_WIDTH'(time_now_i)),
    .edge_mask_i  (edge_mask_q),
    .count_o      (count),
    .reverse_o    (reverse),
    .last_time_o  (last_time),
    .prior_time_o (prior_time),
    .flags_o      (flags)
  );

  // Hold the sample time for the timeout check
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      now_q <= TIME_WIDTH'(time_now_i);
    end
  end

  // Elapsed time and edge period from the updated state
  assign elapsed = now_q - last_time;
  assign period  = last_time - prior_time;

  always_ff @(posedge clk_i) begin
    if (state_q == qdv_pkg::ST_LOAD) begin
      timeout_hit_q <= CMP_W'(elapsed) > CMP_W'(timeout_q);
      zero_period_q <= (period == '0);
    end
  end

  // Serial divider for scale over period
  qdv_div #(
    .DIVISOR_W (TIME_WIDTH)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (ups_q),
    .divisor_i  (period),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // Sign, saturate and zero the speed
  always_comb begin
    if (timeout_hit_q) begin
      speed_d = '0;
    end else if (zero_period_q) begin
      speed_d = reverse ? qdv_pkg::SPEED_MIN : qdv_pkg::SPEED_MAX;
    end else if (reverse) begin
      speed_d = quotient[qdv_pkg::DIVIDEND_W-1] ? qdv_pkg::SPEED_MIN : -quotient;
    end else begin
      speed_d = quotient[qdv_pkg::DIVIDEND_W-1] ? qdv_pkg::SPEED_MAX : quotient;
    end
  end

  // Sequencer: next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      qdv_pkg::ST_IDLE: if (in_acc) state_d = qdv_pkg::ST_LOAD;
      qdv_pkg::ST_LOAD: state_d = qdv_pkg::ST_DIV;
      qdv_pkg::ST_DIV:  if (div_done) state_d = qdv_pkg::ST_DONE;
      qdv_pkg::ST_DONE: if (out_free) state_d = qdv_pkg::ST_IDLE;
      default:          state_d = qdv_pkg::ST_IDLE;
    endcase
  end

  // Sequencer: outputs
  always_comb begin
    in_stall_o = 1'b1;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      qdv_pkg::ST_IDLE: in_stall_o = 1'b0;
      qdv_pkg::ST_LOAD: div_start  = 1'b1;
      qdv_pkg::ST_DIV:  ;
      qdv_pkg::ST_DONE: out_load   = out_free;
      default:          ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= qdv_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
    end
  end

  // Output word register
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      position_o       <= qdv_pkg::POS_W'(count);
      moving_reverse_o <= reverse;
      speed_o          <= speed_d;
      edge_counted_o   <= flags.counted;
      bad_transition_o <= flags.bad;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### hdl/qdv_checker.sv
// Port-level checks of the quadrature decoder with period velocity.
// Uses the assertion macros header; bound to the top level below.
`include "quadrature_decoder_velocity_top_macros.svh"

module qdv_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic signed [qdv_pkg::POS_W-1:0]  position_o,
  input logic                              moving_reverse_o,
  input logic signed [qdv_pkg::SPEED_W-1:0] speed_o,
  input logic                              edge_counted_o,
  input logic                              bad_transition_o
);

  logic in_acc, out_held, out_rev, out_fwd;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_held = out_valid_o && out_stall_i;
  assign out_rev  = out_valid_o && moving_reverse_o;
  assign out_fwd  = out_valid_o && !moving_reverse_o;

  // One word in flight: an accepted word closes the input side
  `QDV_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_acc, in_stall_o)

  // A stalled result word holds
  `QDV_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_held, out_valid_o && $stable({position_o, speed_o}))

  // A double change never counts
  `QDV_ASSERT_IMP(a_bad_not_counted, clk_i, rst_ni, out_valid_o && bad_transition_o, !edge_counted_o)

  // Speed sign follows the direction
  `QDV_ASSERT_IMP(a_rev_sign, clk_i, rst_ni, out_rev, speed_o <= 0)
  `QDV_ASSERT_IMP(a_fwd_sign, clk_i, rst_ni, out_fwd, speed_o >= 0)

endmodule

bind quadrature_decoder_velocity_top qdv_checker u_qdv_checker (.*);
